// File: rtl/core/mvlc_pkg.sv
// Shared constants, types and codes of the multilevel VLC table decoder.
`timescale 1ns / 1ps

package mvlc_pkg;

  // Node table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int WORD_W      = 32;

  // Walk limits
  localparam int MAX_LEVELS  = 8;
  localparam int LEVEL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int WINDOW_BITS = 32;
  localparam int USED_W      = 6;   // holds 0..WINDOW_BITS
  localparam int WIDTH_W     = 5;   // lookup width and code length field

  // Node word layout
  localparam int NODE_TERMINAL_BIT = 31;
  localparam int FIRST_WIDTH_LSB   = 21;
  localparam int NODE_BITS_LSB     = 16;
  localparam int SYMBOL_W          = 16;
  localparam logic [SYMBOL_W-1:0] NODE_ILLEGAL = 16'hFFFF;

  // Input function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // Command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef enum logic [1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_ILLEGAL = 2'd1,
    STATUS_FAULT   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_DROP   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [ADDR_W-1:0]  addr;
    logic [WORD_W-1:0]  data;  // node word for a load, bit window for a decode
  } cmd_t;

endpackage

// File: rtl/core/mvlc_front.sv
// Front end: accept input items, classify them and queue them for the walker.
`timescale 1ns / 1ps

module mvlc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       func_i,
  input  logic [mvlc_pkg::ADDR_W-1:0] entry_addr_i,
  input  logic [mvlc_pkg::WORD_W-1:0] entry_word_i,
  input  logic [mvlc_pkg::WORD_W-1:0] bit_window_i,
  output logic                       cmd_valid_o,
  output mvlc_pkg::cmd_t             cmd_o,
  input  logic                       cmd_ready_i
);
  import mvlc_pkg::*;

  cmd_t                 queue_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] count_q;
  cmd_t                 cmd_in;
  logic                 do_push, do_pop;

  // Classify: decode, load in range, or load beyond the table (dropped)
  always_comb begin
    cmd_in.addr = entry_addr_i;
    if (func_i == FUNC_DECODE) begin
      cmd_in.kind = CMD_DECODE;
      cmd_in.data = bit_window_i;
    end else begin
      cmd_in.data = entry_word_i;
      if ({1'b0, entry_addr_i} < (ADDR_W + 1)'(TABLE_DEPTH)) begin
        cmd_in.kind = CMD_LOAD;
      end else begin
        cmd_in.kind = CMD_DROP;
      end
    end
  end

  assign full        = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/mvlc_back.sv
// Back end: node table store, table walker and result register.
`timescale 1ns / 1ps

module mvlc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  mvlc_pkg::cmd_t                cmd_i,
  output logic                          cmd_ready_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [mvlc_pkg::SYMBOL_W-1:0] symbol_o,
  output logic [mvlc_pkg::WIDTH_W-1:0]  code_length_o,
  output mvlc_pkg::status_e             status_o
);
  import mvlc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK
  } state_e;

  localparam int SUM_W  = USED_W + 1;
  localparam int ADDR_SUM_W = WORD_W + 1;

  logic [WORD_W-1:0]   mem [TABLE_DEPTH];
  logic [WORD_W-1:0]   rdata_q;

  state_e              state_q;
  logic [WORD_W-1:0]   win_q;
  logic [USED_W-1:0]   used_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [SYMBOL_W-1:0] base_q;
  logic [LEVEL_W-1:0]  level_q;
  logic [WIDTH_W-1:0]  first_width_q;

  logic                res_valid_q;
  logic [SYMBOL_W-1:0] symbol_q;
  logic [WIDTH_W-1:0]  length_q;
  status_e             status_q;

  logic                  out_free;
  logic                  res_set;
  logic                  mem_we, mem_re;
  logic [SUM_W-1:0]      lk_sum;
  logic                  lk_overrun;
  logic [USED_W-1:0]     lk_shift;
  logic [WORD_W-1:0]     lk_bits;
  logic [ADDR_SUM_W-1:0] lk_addr;
  logic                  lk_fault;
  logic                  ck_term;
  logic [WIDTH_W-1:0]    ck_len;
  logic [SYMBOL_W-1:0]   ck_value;
  logic                  ck_len_bad;
  logic                  ck_last;

  assign cmd_ready_o   = (state_q == S_IDLE);
  assign empty         = !res_valid_q;
  assign symbol_o      = symbol_q;
  assign code_length_o = length_q;
  assign status_o      = status_q;
  assign out_free      = !res_valid_q || pop;

  // Lookup address: base plus the next width bits of the remaining window
  always_comb begin
    lk_sum     = SUM_W'(used_q) + SUM_W'(width_q);
    lk_overrun = lk_sum > SUM_W'(WINDOW_BITS);
    lk_shift   = USED_W'(WORD_W) - USED_W'(width_q);
    lk_bits    = (width_q == '0) ? '0 : (win_q >> lk_shift);
    lk_addr    = ADDR_SUM_W'(base_q) + ADDR_SUM_W'(lk_bits);
    lk_fault   = lk_overrun || (lk_addr >= ADDR_SUM_W'(TABLE_DEPTH));
  end

  // Examine the node word just read
  always_comb begin
    ck_term    = rdata_q[NODE_TERMINAL_BIT];
    ck_len     = rdata_q[NODE_BITS_LSB +: WIDTH_W];
    ck_value   = rdata_q[SYMBOL_W-1:0];
    ck_len_bad = (SUM_W'(ck_len) < SUM_W'(used_q)) ||
                 (SUM_W'(ck_len) > SUM_W'(WINDOW_BITS));
    ck_last    = (level_q == LEVEL_W'(MAX_LEVELS - 1));
  end

  // A walk finishes this cycle and loads the result register
  assign res_set = out_free &&
                   (((state_q == S_LOOKUP) && lk_fault) ||
                    ((state_q == S_CHECK) && (ck_term || ck_last)));

  assign mem_we = (state_q == S_IDLE) && cmd_valid_i && (cmd_i.kind == CMD_LOAD);
  assign mem_re = (state_q == S_LOOKUP) && !lk_fault;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_i.addr] <= cmd_i.data;
    end
    if (mem_re) begin
      rdata_q <= mem[lk_addr[ADDR_W-1:0]];
    end
    // Shadow of entry 0's first lookup width
    if (mem_we && (cmd_i.addr == '0)) begin
      first_width_q <= cmd_i.data[FIRST_WIDTH_LSB +: WIDTH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      win_q       <= '0;
      used_q      <= '0;
      width_q     <= '0;
      base_q      <= '0;
      level_q     <= '0;
      symbol_q    <= '0;
      length_q    <= '0;
      status_q    <= STATUS_VALID;
    end else begin
      if (pop && res_valid_q && !res_set) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && (cmd_i.kind == CMD_DECODE)) begin
            win_q   <= cmd_i.data;
            used_q  <= '0;
            width_q <= first_width_q;
            base_q  <= '0;
            level_q <= '0;
            state_q <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (!lk_fault) begin
            state_q <= S_CHECK;
          end else if (out_free) begin
            res_valid_q <= 1'b1;
            symbol_q    <= '0;
            length_q    <= '0;
            status_q    <= STATUS_FAULT;
            state_q     <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (ck_term || ck_last) begin
            // Hold here until the result register is free
            if (out_free) begin
              res_valid_q <= 1'b1;
              state_q     <= S_IDLE;
              if (!ck_term || ck_len_bad) begin
                symbol_q <= '0;
                length_q <= '0;
                status_q <= STATUS_FAULT;
              end else begin
                symbol_q <= ck_value;
                length_q <= ck_len;
                status_q <= (ck_value == NODE_ILLEGAL) ? STATUS_ILLEGAL : STATUS_VALID;
              end
            end
          end else begin
            // Advance one level: consume the bits just looked at
            win_q   <= win_q << width_q;
            used_q  <= USED_W'(lk_sum);
            width_q <= ck_len;
            base_q  <= ck_value;
            level_q <= level_q + 1'b1;
            state_q <= S_LOOKUP;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/multilevel_vlc_table_decoder.sv
// Top level of the multilevel lookup-table VLC decoder.
`timescale 1ns / 1ps

// Both channels behave as queues. Push an item when full is low: func 0
// writes entry_word into the node table at entry_addr, func 1 decodes one
// codeword from the left-aligned bit_window. Each decode gives exactly one
// result (symbol, code_length, status); loads give none. A result waits on
// the output ports while empty is low and leaves on pop.
// The front end classifies items into a two-deep command queue; the back
// end walks the table one level at a time through a single-port store with
// registered read data. A decode starts from idle and then, per table
// level, forms the address and reads the node word, then examines it; a
// walk fault found at address time ends the walk without the examine step.
// Reset empties the command queue and the result register; the table
// contents are undefined until written and are not cleared. When the
// receiver stops popping, the walker holds its finished result, the
// command queue fills, and full rises.
module multilevel_vlc_table_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          func_i,
  input  logic [mvlc_pkg::ADDR_W-1:0]   entry_addr_i,
  input  logic [mvlc_pkg::WORD_W-1:0]   entry_word_i,
  input  logic [mvlc_pkg::WORD_W-1:0]   bit_window_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [mvlc_pkg::SYMBOL_W-1:0] symbol_o,
  output logic [mvlc_pkg::WIDTH_W-1:0]  code_length_o,
  output logic [1:0]                    status_o
);
  import mvlc_pkg::*;

  logic    cmd_valid;
  logic    cmd_ready;
  cmd_t    cmd;
  status_e status;

  // Front end: transfer in, classify, queue
  mvlc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .func_i       (func_i),
    .entry_addr_i (entry_addr_i),
    .entry_word_i (entry_word_i),
    .bit_window_i (bit_window_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  // Back end: table store, walker, result register
  mvlc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_ready_o   (cmd_ready),
    .empty         (empty),
    .pop           (pop),
    .symbol_o      (symbol_o),
    .code_length_o (code_length_o),
    .status_o      (status)
  );

  assign status_o = status;

endmodule
